@@ rtl/spd_pkg.sv @@
`timescale 1ns / 1ps
package spd_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EVEN      = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_NOT_INV   = 3'd3;
  localparam logic [2:0] ST_TWO_FIXED = 3'd4;
  localparam logic [2:0] ST_BITONIC   = 3'd5;
  localparam logic [2:0] ST_FORM      = 3'd6;
  localparam logic [2:0] ST_TOO_LONG  = 3'd7;

  // Job handed from the loader to the decoder.
  typedef struct packed {
    logic [7:0] len;
    logic       overflow;
  } job_t;

endpackage

@@ rtl/spd_loader.sv @@
`timescale 1ns / 1ps
module spd_loader import spd_pkg::*; #(
  parameter int CAP = 129
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] element,
  input  logic       last_element,
  input  logic       dec_busy,
  output logic       wr_en,
  output logic [7:0] wr_addr,
  output logic [7:0] wr_data,
  output logic       job_valid,
  output job_t       job,
  input  logic       job_ready
);

  logic [7:0] load_count;
  logic       overflow;
  logic       full;
  logic       take;

  // A finished frame waits here until the decoder takes it. While the decoder
  // is still reading the permutation memory no new element may overwrite it.
  assign full     = job_valid;
  assign in_ready = !full && !dec_busy;
  assign take     = in_valid && in_ready;
  assign wr_en    = take && (32'(load_count) < CAP);
  assign wr_addr  = load_count;
  assign wr_data  = element;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      overflow   <= 1'b0;
      job_valid  <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        job_valid <= 1'b0;
      end
      if (take) begin
        if (last_element) begin
          job_valid    <= 1'b1;
          job.len      <= wr_en ? load_count + 8'd1 : load_count;
          job.overflow <= overflow || !wr_en;
          load_count   <= '0;
          overflow     <= 1'b0;
        end else if (wr_en) begin
          load_count <= load_count + 8'd1;
        end else begin
          overflow <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/spd_decoder.sv @@
`timescale 1ns / 1ps
module spd_decoder import spd_pkg::*; #(
  parameter int MAX_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [7:0]  wr_addr,
  input  logic [7:0]  wr_data,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_ready,
  output logic        busy,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [63:0] value,
  output logic [6:0]  bit_count,
  output logic [2:0]  status
);

  localparam int DEPTH = 2 * MAX_BITS + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_RD_I  = 4'd2;
  localparam logic [3:0] S_RD_S  = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_BT_RD = 4'd5;
  localparam logic [3:0] S_BT    = 4'd6;
  localparam logic [3:0] S_BS    = 4'd7;
  localparam logic [3:0] S_FORM  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // Permutation store has the loader write port and one read port for the
  // decoder; the order store has one write and one read port.
  logic [7:0] perm_mem [DEPTH];
  logic [7:0] order_mem [DEPTH];
  logic [DEPTH-1:0] seen;
  logic [DEPTH-1:0] bits;

  logic [3:0] state;
  logic [7:0] n, i, j, k, s, prev;
  logic [7:0] p_raddr, p_rdata, o_raddr, o_rdata;
  logic       o_we;
  logic [7:0] o_waddr, o_wdata;
  logic       fixed, desc, pass;
  logic       chk_pass;
  logic [63:0] decoded;

  always_ff @(posedge clk) begin
    if (wr_en) perm_mem[wr_addr] <= wr_data;
    p_rdata <= perm_mem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (o_we) order_mem[o_waddr] <= o_wdata;
    o_rdata <= order_mem[o_raddr];
  end

  assign job_ready = (state == S_IDLE) && !res_valid;
  assign busy      = (state != S_IDLE);

  // The pair under test is in range, self-inverse and not a second fixed point.
  assign chk_pass = (state == S_CHK) && (s < n) && (p_rdata == i) &&
                    !((s == i) && fixed);

  always_comb begin
    p_raddr = i;
    if (state == S_RD_S) p_raddr = p_rdata;
    o_raddr = i;
  end

  // Decoded value: bit b comes from the (b+1)-th entry below the marker.
  always_comb begin
    for (int b = 0; b < 64; b++) begin
      decoded[b] = (b < 32'(n >> 1)) ? bits[32'(n) - 2 - b] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    o_we <= !rst && (chk_pass || (state == S_BS));
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            n <= job.len;
            value <= '0;
            bit_count <= '0;
            if (job.overflow) begin
              status <= ST_TOO_LONG;
              state  <= S_DONE;
            end else if (!job.len[0]) begin
              status <= ST_EVEN;
              state  <= S_DONE;
            end else begin
              seen  <= '0;
              bits  <= '0;
              i     <= '0;
              j     <= '0;
              k     <= job.len - 8'd1;
              fixed <= 1'b0;
              state <= S_CLR;
            end
          end
        end
        S_CLR: begin
          // p_raddr = i is issued now.
          if (i == n) begin
            i     <= 8'd1;
            desc  <= 1'b0;
            pass  <= 1'b1;
            state <= S_BT_RD;
          end else if (seen[i]) begin
            i <= i + 8'd1;
          end else begin
            state <= S_RD_I;
          end
        end
        S_RD_I: state <= S_RD_S; // p_rdata = perm[i] after this edge
        S_RD_S: begin
          s     <= p_rdata;
          state <= S_CHK;
        end
        S_CHK: begin
          if (s >= n) begin
            status <= ST_RANGE;
            state  <= S_DONE;
          end else if (p_rdata != i) begin
            status <= ST_NOT_INV;
            state  <= S_DONE;
          end else if (s == i && fixed) begin
            status <= ST_TWO_FIXED;
            state  <= S_DONE;
          end else begin
            seen    <= seen | (DEPTH'(1) << i) | (DEPTH'(1) << s);
            o_waddr <= j;
            o_wdata <= s;
            j <= j + 8'd1;
            if (s == i) begin
              fixed <= 1'b1;
              i     <= i + 8'd1;
              state <= S_CLR;
            end else begin
              // second order write next cycle
              state <= S_BS;
            end
          end
        end
        S_BS: begin
          o_waddr <= k;
          o_wdata <= i;
          k     <= k - 8'd1;
          i     <= i + 8'd1;
          state <= S_CLR;
        end
        S_BT_RD: begin
          // walk index back to 0, prime prev
          prev  <= 8'd0;
          i     <= 8'd0;
          j     <= 8'd0;
          state <= S_BT;
        end
        S_BT: begin
          // o_rdata holds order[i-1], registered from the read of index i-1; a simple
          // two-phase walk: index i issued, data arrives next cycle.
          i <= i + 8'd1;
          if (i >= 8'd2) begin
            if (prev < o_rdata) begin
              if (desc) pass <= 1'b0;
              if (!desc) bits[o_rdata] <= 1'b1;
            end else begin
              desc <= 1'b1;
            end
          end
          if (i == 8'd1) bits[o_rdata] <= 1'b1;
          if (i >= 8'd1) prev <= o_rdata;
          if (i == n) begin
            state <= S_FORM;
          end
        end
        S_FORM: begin
          if (!desc || !pass) begin
            status <= ST_BITONIC;
          end else if (!bits[n-8'd1] ||
                       ((bits & ((DEPTH'(1) << (n >> 1)) - DEPTH'(1))) != '0)) begin
            status <= ST_FORM;
          end else begin
            status    <= ST_OK;
            value     <= decoded;
            bit_count <= 7'(n >> 1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid) begin
            res_valid <= 1'b1;
            if (status != ST_OK) begin
              value     <= '0;
              bit_count <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/sip_permutation_decoder.sv @@
`timescale 1ns / 1ps
// Self-inverting permutation decoder.
// s_axis beats carry one permutation element each (tdata = element), with
// tlast on the final element of a frame. m_axis returns one beat per frame:
// tdata = {status, bit_count, value}, status 0 meaning the value is valid.
// The loader stores one element per cycle into the permutation memory while
// s_axis_tready is high and hands the frame length to the decoder through a
// one-entry job register. The decoder then sweeps the stored entries: the
// inverse and fixed-point pass over each pair of swapped indices and the
// fixed point, then a walk over the pi order, then the form check and the
// result. An even-length or too-long frame answers without the sweep, and a
// frame that fails early in the sweep answers sooner than a valid frame.
// s_axis_tready stays low while the decoder works, so frames are handled one
// at a time, but the next frame may load while the result of the previous
// one waits. Reset clears all control state; the stores need no clearing. A
// stalled receiver holds the result beat, and once a further frame has loaded
// the input stalls as well.
module sip_permutation_decoder import spd_pkg::*; #(
  parameter int MAX_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // element
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // value, bit_count, status, zero pad
);

  logic       wr_en, job_valid, job_ready, dec_busy;
  logic [7:0] wr_addr, wr_data;
  job_t       job;
  logic [63:0] value;
  logic [6:0]  bit_count;
  logic [2:0]  status;

  spd_loader #(.CAP(2 * MAX_BITS + 1)) u_load (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .element(s_axis_tdata), .last_element(s_axis_tlast), .dec_busy,
    .wr_en, .wr_addr, .wr_data, .job_valid, .job, .job_ready
  );

  spd_decoder #(.MAX_BITS(MAX_BITS)) u_dec (
    .clk, .rst, .wr_en, .wr_addr, .wr_data, .job_valid, .job, .job_ready,
    .busy(dec_busy), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .value, .bit_count, .status
  );

  assign m_axis_tdata = {6'd0, status, bit_count, value};

endmodule

@@ rtl/spd_checker.sv @@
`timescale 1ns / 1ps
module spd_checker import spd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[73:71] != ST_OK |-> m_axis_tdata[70:0] == '0)
    else $error("error result carries data");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[79:74] == '0)
    else $error("pad bits set");

endmodule

bind sip_permutation_decoder spd_checker u_chk (
  .clk, .rst, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

@@ test/spd_result_checker.sv @@
`timescale 1ns / 1ps
// Watches both streams of the decoder. It keeps its own copy of the loaded
// permutation and predicts the result beat for every frame.
module spd_result_checker import spd_pkg::*; #(
  parameter int MAX_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,
  output int          fail_count,
  output int          pending,
  output int          frames_seen,
  output int          ok_seen
);

  localparam int CAP = 2 * MAX_BITS + 1;

  // Same layout as the low bits of the result beat: value lowest.
  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  bit_count;
    logic [63:0] value;
  } decoded_t;

  decoded_t   decoded_q[$];
  logic [7:0] elems[CAP];
  int         held;
  logic       overflow;

  function automatic decoded_t decode_perm(int n);
    decoded_t r;
    logic [7:0] order[CAP];
    logic seen[CAP];
    logic bits[CAP];
    int j, k, s;
    logic fixed, desc, pass;
    r = '0;
    fixed = 0; desc = 0; pass = 1;
    if (n % 2 == 0) begin
      r.status = ST_EVEN;
      return r;
    end
    for (int i = 0; i < CAP; i++) begin
      seen[i] = 0;
      bits[i] = 0;
      order[i] = '0;
    end
    j = 0;
    k = n - 1;
    for (int i = 0; i < n; i++) begin
      if (!seen[i]) begin
        s = elems[i];
        if (s >= n) begin
          r.status = ST_RANGE;
          return r;
        end
        if (elems[s] != i) begin
          r.status = ST_NOT_INV;
          return r;
        end
        seen[i] = 1;
        seen[s] = 1;
        order[j] = 8'(s);
        j++;
        if (s == i) begin
          if (fixed) begin
            r.status = ST_TWO_FIXED;
            return r;
          end
          fixed = 1;
        end else begin
          order[k] = 8'(i);
          k--;
        end
      end
    end
    for (int i = 1; i < n; i++) begin
      if (order[i-1] < order[i]) begin
        if (desc) pass = 0;
      end else begin
        desc = 1;
      end
    end
    if (!desc || !pass) begin
      r.status = ST_BITONIC;
      return r;
    end
    j = 0;
    bits[order[0]] = 1;
    while (j + 1 < n && order[j+1] > order[j]) begin
      j++;
      bits[order[j]] = 1;
    end
    if (!bits[n-1]) begin
      r.status = ST_FORM;
      return r;
    end
    for (int i = 1 + n / 2; i < n; i++) begin
      if (bits[n-1-i]) begin
        r.status = ST_FORM;
        return r;
      end
    end
    for (int i = 0; i < n / 2; i++)
      r.value[i] = bits[n-2-i];
    r.bit_count = 7'(n / 2);
    r.status = ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [79:0] got, logic [79:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    decoded_t got, want;
    if (rst) begin
      held <= 0;
      overflow <= 0;
      fail_count <= 0;
      frames_seen <= 0;
      ok_seen <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        int n;
        logic ovf;
        n = held;
        ovf = overflow;
        if (n < CAP) begin
          elems[n] = s_axis_tdata;
          n++;
        end else begin
          ovf = 1;
        end
        if (s_axis_tlast) begin
          if (ovf)
            decoded_q.insert(decoded_q.size(),
                             '{status: ST_TOO_LONG, bit_count: '0, value: '0});
          else decoded_q.insert(decoded_q.size(), decode_perm(n));
          n = 0;
          ovf = 0;
        end
        held <= n;
        overflow <= ovf;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[73:0];
        frames_seen <= frames_seen + 1;
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata, '0);
        end else begin
          want = decoded_q.pop_front();
          if (want.status == ST_OK) ok_seen <= ok_seen + 1;
          if (got.status != want.status)
            report_mismatch("status", 80'(got.status), 80'(want.status));
          if (got.bit_count != want.bit_count)
            report_mismatch("bit_count", 80'(got.bit_count), 80'(want.bit_count));
          if (got.value != want.value)
            report_mismatch("value", 80'(got.value), 80'(want.value));
          if (m_axis_tdata[79:74] != '0)
            report_mismatch("pad bits", m_axis_tdata, '0);
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

@@ test/sip_permutation_decoder_tb.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for the permutation decoder. Frames are mostly
// well-formed encodings of random integers, with a share of damaged and
// random frames to reach every fault code.
module sip_permutation_decoder_tb;

  localparam int MAX_BITS = 64;
  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  int          fail_count, pending, frames_seen, ok_seen;
  int          beats_sent;
  logic        hold_off;
  logic [7:0]  frame[$];

  sip_permutation_decoder #(.MAX_BITS(MAX_BITS)) i_dut (.*);

  spd_result_checker #(.MAX_BITS(MAX_BITS)) i_checker (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count, .pending, .frames_seen, .ok_seen
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Gap lengths: mostly none or short, occasionally long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Builds the permutation that encodes the given integer of nb bits
  // (nb + 1 digits with the leading one, in the form 0..0<integer>1).
  function automatic void encode_value(logic [63:0] w, int nb);
    int n, m, lo, hi;
    logic b[129];
    int inc[$], dec[$], order[129], p[129];
    n = 2 * nb + 1;
    for (int i = 0; i < n; i++) b[i] = 0;
    b[n-1] = 1;
    for (int i = 0; i < nb; i++) b[n-2-i] = w[i];
    for (int i = 0; i < n; i++)
      if (b[i]) inc.insert(inc.size(), i);
      else dec.push_front(i);
    m = 0;
    foreach (inc[i]) order[m++] = inc[i];
    foreach (dec[i]) order[m++] = dec[i];
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      p[order[lo]] = order[hi];
      p[order[hi]] = order[lo];
      lo++;
      hi--;
    end
    p[order[lo]] = order[lo];
    frame.delete();
    for (int i = 0; i < n; i++) frame.insert(frame.size(), 8'(p[i]));
  endfunction

  task automatic send_frame();
    foreach (frame[i]) begin
      int g;
      g = gap_len();
      if (g > 0) begin
        s_axis_tvalid <= 0;
        repeat (g) @(posedge clk);
      end
      s_axis_tvalid <= 1;
      s_axis_tdata <= frame[i];
      s_axis_tlast <= (i == frame.size() - 1);
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      beats_sent++;
    end
    s_axis_tvalid <= 0;
  endtask

  task automatic random_encoded(int maxb);
    logic [63:0] w;
    int nb;
    nb = $urandom_range(0, maxb);
    w = {$urandom, $urandom};
    if (nb < 64) w &= (64'd1 << nb) - 1;
    encode_value(w, nb);
  endtask

  // Receiver: random stalls, plus one long hold-off while frames pile up.
  initial begin
    m_axis_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) m_axis_tready <= 0;
      else if ($urandom_range(0, 99) < 20) m_axis_tready <= 0;
      else if ($urandom_range(0, 199) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else m_axis_tready <= 1;
    end
  end

  // Watchdog: cycles with no beat on either side.
  initial begin
    int idle;
    idle = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", pending);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tlast = 0;
    hold_off = 0;
    beats_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed frames.
    encode_value(64'd0, 0); send_frame();                       // single element
    encode_value(64'd0, 1); send_frame();
    encode_value(64'd1, 1); send_frame();
    encode_value(64'hFFFF_FFFF_FFFF_FFFF, 64); send_frame();    // largest value
    frame = '{8'd0, 8'd1}; send_frame();                        // even length
    frame = '{8'd2, 8'd1, 8'd255}; send_frame();                // not self-inverse
    frame = '{8'd1, 8'd2, 8'd0}; send_frame();                  // not self-inverse
    frame = '{8'd0, 8'd1, 8'd2}; send_frame();                  // two fixed points
    frame = '{8'd1, 8'd0, 8'd2}; send_frame();                  // well-formed, value 1
    frame = '{8'd2, 8'd1, 8'd0}; send_frame();                  // well-formed, value 0
    frame.delete();
    for (int i = 0; i < 130; i++) frame.insert(frame.size(), 8'hAA); // too long
    send_frame();

    // Long hold-off on the result side while frames keep arriving.
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      repeat (6) begin
        random_encoded(4);
        send_frame();
      end
    join

    // Random frames until about 450 beats in all have gone in.
    while (beats_sent < 450) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        random_encoded($urandom_range(0, 9) == 0 ? 12 : 5);
      end else if (kind < 80) begin
        random_encoded(5);
        frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind < 95) begin
        frame.delete();
        repeat ($urandom_range(1, 8)) frame.insert(frame.size(), 8'($urandom_range(0, 8)));
      end else begin
        frame.delete();
        repeat ($urandom_range(1, 4)) frame.insert(frame.size(), 8'($urandom));
      end
      send_frame();
    end

    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    $display("%0d input beats, %0d result beats, %0d of them decoded cleanly",
             beats_sent, frames_seen, ok_seen);
    if (fail_count == 0 && pending == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
